### rtl/bic_pkg.sv
package bic_pkg;

  localparam int MAX_DIMS = 3;
  localparam int COORD_WIDTH = 32;
  localparam int IDX_WIDTH = 63;
  localparam int ACC_WIDTH = 64;
  localparam int EXT_WIDTH = COORD_WIDTH + 1;
  localparam int DIM_WIDTH = $clog2(MAX_DIMS + 1);
  localparam int N_STEPS = IDX_WIDTH;
  localparam int MUL_STEPS = EXT_WIDTH;
  localparam int STEP_WIDTH = $clog2(N_STEPS + 1);
  localparam int CELLS_PER_PASS = N_STEPS + 1;
  localparam int N_STAGES = MAX_DIMS * CELLS_PER_PASS;
  localparam int CFG_IDX_WIDTH = 3;

  localparam logic CMD_LIN = 1'b0;
  localparam logic CMD_DELIN = 1'b1;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_DIMS = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LO0 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_HI0 = 3'd4;

  typedef logic [MAX_DIMS-1:0][EXT_WIDTH-1:0] ext_arr_t;
  typedef logic [MAX_DIMS-1:0][COORD_WIDTH-1:0] coord_arr_t;

  // acc: dividend/quotient or multiplicand; prod: product or remainder;
  // dat: coordinate offsets when linearizing, recovered coordinates otherwise.
  typedef struct packed {
    logic                 vld;
    logic                 cmd;
    logic                 bad;
    logic [ACC_WIDTH-1:0] acc;
    logic [ACC_WIDTH-1:0] prod;
    ext_arr_t             dat;
  } cell_t;

endpackage

### rtl/bic_req_if.sv
interface bic_req_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic signed [bic_pkg::COORD_WIDTH-1:0] coord_0;
  logic signed [bic_pkg::COORD_WIDTH-1:0] coord_1;
  logic signed [bic_pkg::COORD_WIDTH-1:0] coord_2;
  logic [bic_pkg::IDX_WIDTH-1:0]       index;

  modport source (output valid, cmd, coord_0, coord_1, coord_2, index, input ready);
  modport sink (input valid, cmd, coord_0, coord_1, coord_2, index, output ready);
endinterface

### rtl/bic_rsp_if.sv
interface bic_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [bic_pkg::ACC_WIDTH-1:0]       out_index;
  logic signed [bic_pkg::COORD_WIDTH-1:0] out_coord_0;
  logic signed [bic_pkg::COORD_WIDTH-1:0] out_coord_1;
  logic signed [bic_pkg::COORD_WIDTH-1:0] out_coord_2;
  logic                                bad_box;

  modport source (output valid, out_index, out_coord_0, out_coord_1, out_coord_2, bad_box,
                  input ready);
  modport sink (input valid, out_index, out_coord_0, out_coord_1, out_coord_2, bad_box,
                output ready);
endinterface

### rtl/bic_cell.sv
module bic_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic [bic_pkg::STEP_WIDTH-1:0]     step_i,
  input  logic [bic_pkg::DIM_WIDTH-1:0]      pass_i,
  input  logic [bic_pkg::DIM_WIDTH-1:0]      dims_i,
  input  bic_pkg::ext_arr_t                  ext_i,
  input  bic_pkg::cell_t                     cell_i,
  output bic_pkg::cell_t                     cell_o
);

  bic_pkg::cell_t                     cell_d, cell_q;
  logic [bic_pkg::DIM_WIDTH-1:0]      dim;
  logic [bic_pkg::EXT_WIDTH-1:0]      ext;
  logic [bic_pkg::EXT_WIDTH:0]        shifted;
  logic [bic_pkg::EXT_WIDTH:0]        diff;
  logic                               fits;
  logic [bic_pkg::STEP_WIDTH-1:0]     bit_sel;
  logic [bic_pkg::ACC_WIDTH-1:0]      addend;

  // Delinearize walks the dimensions from the last one, so skipped passes come first.
  assign dim = (cell_i.cmd == bic_pkg::CMD_DELIN)
             ? bic_pkg::DIM_WIDTH'(bic_pkg::MAX_DIMS - 1) - pass_i : pass_i;
  assign ext = ext_i[dim];
  assign shifted = {cell_i.prod[bic_pkg::EXT_WIDTH-1:0], cell_i.acc[bic_pkg::IDX_WIDTH-1]};
  assign diff = shifted - {1'b0, ext};
  assign fits = shifted >= {1'b0, ext};
  assign bit_sel = bic_pkg::STEP_WIDTH'(bic_pkg::MUL_STEPS - 1) - step_i;
  assign addend = ext[bit_sel] ? cell_i.acc : '0;

  always_comb begin
    cell_d = cell_i;
    if (cell_i.vld && !cell_i.bad && (dim < dims_i)) begin
      if (cell_i.cmd == bic_pkg::CMD_DELIN) begin
        // One restoring division step: quotient bit enters at the bottom of acc.
        cell_d.prod = bic_pkg::ACC_WIDTH'(fits ? diff[bic_pkg::EXT_WIDTH-1:0]
                                              : shifted[bic_pkg::EXT_WIDTH-1:0]);
        cell_d.acc  = {1'b0, cell_i.acc[bic_pkg::IDX_WIDTH-2:0], fits};
      end else if (step_i < bic_pkg::STEP_WIDTH'(bic_pkg::MUL_STEPS)) begin
        // One shift-add multiply step, extent bits taken from the top down.
        cell_d.prod = {cell_i.prod[bic_pkg::ACC_WIDTH-2:0], 1'b0} + addend;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/bic_pass_end.sv
module bic_pass_end (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [bic_pkg::DIM_WIDTH-1:0]  pass_i,
  input  logic [bic_pkg::DIM_WIDTH-1:0]  dims_i,
  input  bic_pkg::coord_arr_t            lo_i,
  input  bic_pkg::cell_t                 cell_i,
  output bic_pkg::cell_t                 cell_o
);

  bic_pkg::cell_t                    cell_d, cell_q;
  logic [bic_pkg::DIM_WIDTH-1:0]     dim;
  logic [bic_pkg::EXT_WIDTH-1:0]     off;
  logic [bic_pkg::COORD_WIDTH-1:0]   coord;

  assign dim = (cell_i.cmd == bic_pkg::CMD_DELIN)
             ? bic_pkg::DIM_WIDTH'(bic_pkg::MAX_DIMS - 1) - pass_i : pass_i;
  assign off = cell_i.dat[dim];
  assign coord = cell_i.prod[bic_pkg::COORD_WIDTH-1:0] + lo_i[dim];

  always_comb begin
    cell_d = cell_i;
    if (cell_i.vld && !cell_i.bad && (dim < dims_i)) begin
      cell_d.prod = '0;
      if (cell_i.cmd == bic_pkg::CMD_DELIN) begin
        cell_d.dat[dim] = {1'b0, coord};
      end else begin
        cell_d.acc = cell_i.prod
                   + {{(bic_pkg::ACC_WIDTH - bic_pkg::EXT_WIDTH){off[bic_pkg::EXT_WIDTH-1]}},
                      off};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

### rtl/box_index_converter.sv
// Channel  Dir  Carries
// req_i    in   cmd, coord_0..coord_2, index
// rsp_o    out  out_index, out_coord_0..out_coord_2, bad_box
// cfg_*    in   write enable, register index, write data
//
// One request is taken per cycle while the output register is empty or its result is taken.
// Each request enters the first of 192 chain cells (63 bit-step cells plus one closing
// cell for each of three dimensions) on the edge that takes it; the output register follows.
// Reset clears the registers to a one-dimensional box at zero and empties the chain.
// When the output register holds a result that is not taken, the whole chain holds.
module box_index_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  bic_req_if.sink                              req_i,
  bic_rsp_if.source                            rsp_o,
  input  logic                                 cfg_we_i,
  input  logic [bic_pkg::CFG_IDX_WIDTH-1:0]    cfg_idx_i,
  input  logic [bic_pkg::COORD_WIDTH-1:0]      cfg_wdata_i
);

  logic [bic_pkg::DIM_WIDTH-1:0]    dims_q;
  bic_pkg::coord_arr_t              lo_q, hi_q;
  logic [bic_pkg::DIM_WIDTH-1:0]    dims_use;
  bic_pkg::ext_arr_t                ext;
  logic [bic_pkg::MAX_DIMS-1:0]     dim_bad;
  logic                             bad;
  logic                             en;
  bic_pkg::coord_arr_t              coord_in;
  bic_pkg::cell_t                   st [bic_pkg::N_STAGES+1];
  bic_pkg::cell_t                   out_q;
  logic                             out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= bic_pkg::DIM_WIDTH'(1);
      lo_q   <= '0;
      hi_q   <= '0;
    end else if (cfg_we_i) begin
      for (int d = 0; d < bic_pkg::MAX_DIMS; d++) begin
        if (cfg_idx_i == bic_pkg::REG_LO0 + bic_pkg::CFG_IDX_WIDTH'(d)) begin
          lo_q[d] <= cfg_wdata_i;
        end
        if (cfg_idx_i == bic_pkg::REG_HI0 + bic_pkg::CFG_IDX_WIDTH'(d)) begin
          hi_q[d] <= cfg_wdata_i;
        end
      end
      if (cfg_idx_i == bic_pkg::REG_DIMS) begin
        dims_q <= cfg_wdata_i[bic_pkg::DIM_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    if (dims_q == '0) begin
      dims_use = bic_pkg::DIM_WIDTH'(1);
    end else if (dims_q > bic_pkg::DIM_WIDTH'(bic_pkg::MAX_DIMS)) begin
      dims_use = bic_pkg::DIM_WIDTH'(bic_pkg::MAX_DIMS);
    end else begin
      dims_use = dims_q;
    end
  end

  // Extent hi - lo + 1 is positive and at most 2^COORD_WIDTH for a good box.
  always_comb begin
    logic [bic_pkg::EXT_WIDTH:0] span;
    for (int d = 0; d < bic_pkg::MAX_DIMS; d++) begin
      span = {{2{hi_q[d][bic_pkg::COORD_WIDTH-1]}}, hi_q[d]}
           - {{2{lo_q[d][bic_pkg::COORD_WIDTH-1]}}, lo_q[d]}
           + (bic_pkg::EXT_WIDTH+1)'(1);
      ext[d] = span[bic_pkg::EXT_WIDTH-1:0];
      dim_bad[d] = (bic_pkg::DIM_WIDTH'(d) < dims_use)
                && (span[bic_pkg::EXT_WIDTH] || (span == '0));
    end
  end
  assign bad = |dim_bad;

  assign en = !out_vld_q || rsp_o.ready;
  assign req_i.ready = en;

  assign coord_in[0] = req_i.coord_0;
  assign coord_in[1] = req_i.coord_1;
  assign coord_in[2] = req_i.coord_2;

  always_comb begin
    st[0].vld  = req_i.valid;
    st[0].cmd  = req_i.cmd;
    st[0].bad  = bad;
    st[0].prod = '0;
    st[0].acc  = (req_i.cmd == bic_pkg::CMD_DELIN) ? {1'b0, req_i.index} : '0;
    for (int d = 0; d < bic_pkg::MAX_DIMS; d++) begin
      st[0].dat[d] = (req_i.cmd == bic_pkg::CMD_DELIN) ? '0
                   : {coord_in[d][bic_pkg::COORD_WIDTH-1], coord_in[d]}
                     - {lo_q[d][bic_pkg::COORD_WIDTH-1], lo_q[d]};
    end
  end

  for (genvar k = 0; k < bic_pkg::MAX_DIMS; k++) begin : g_pass
    for (genvar s = 0; s < bic_pkg::N_STEPS; s++) begin : g_step
      bic_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en),
        .step_i (bic_pkg::STEP_WIDTH'(s)),
        .pass_i (bic_pkg::DIM_WIDTH'(k)),
        .dims_i (dims_use),
        .ext_i  (ext),
        .cell_i (st[k*bic_pkg::CELLS_PER_PASS + s]),
        .cell_o (st[k*bic_pkg::CELLS_PER_PASS + s + 1])
      );
    end
    bic_pass_end u_end (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .pass_i (bic_pkg::DIM_WIDTH'(k)),
      .dims_i (dims_use),
      .lo_i   (lo_q),
      .cell_i (st[k*bic_pkg::CELLS_PER_PASS + bic_pkg::N_STEPS]),
      .cell_o (st[(k+1)*bic_pkg::CELLS_PER_PASS])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= st[bic_pkg::N_STAGES].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= st[bic_pkg::N_STAGES];
    end
  end

  assign rsp_o.valid = out_vld_q;
  assign rsp_o.bad_box = out_q.bad;
  assign rsp_o.out_index = (out_q.bad || out_q.cmd == bic_pkg::CMD_DELIN) ? '0 : out_q.acc;
  assign rsp_o.out_coord_0 = (out_q.cmd == bic_pkg::CMD_DELIN && !out_q.bad)
                           ? out_q.dat[0][bic_pkg::COORD_WIDTH-1:0] : '0;
  assign rsp_o.out_coord_1 = (out_q.cmd == bic_pkg::CMD_DELIN && !out_q.bad)
                           ? out_q.dat[1][bic_pkg::COORD_WIDTH-1:0] : '0;
  assign rsp_o.out_coord_2 = (out_q.cmd == bic_pkg::CMD_DELIN && !out_q.bad)
                           ? out_q.dat[2][bic_pkg::COORD_WIDTH-1:0] : '0;

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> st[1].vld)
    else $error("accepted request did not enter the chain");

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(st[bic_pkg::N_STAGES]))
    else $error("chain moved while the output was stalled");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.bad_box) |-> (rsp_o.out_index == '0 && rsp_o.out_coord_0 == '0))
    else $error("bad box result carries data");

  a_delin_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && out_q.cmd == bic_pkg::CMD_DELIN) |-> rsp_o.out_index == '0)
    else $error("delinearize result has a nonzero index");

endmodule

### verif/tb_box_index_converter.sv
module tb_box_index_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bic_pkg::CFG_IDX_WIDTH-1:0] REG_SPARE = 3'd7;
  localparam int HOLD_CYCLES = 600;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic                            cmd;
    bic_pkg::coord_arr_t             coord;
    logic [bic_pkg::IDX_WIDTH-1:0]   index;
  } conv_req_t;

  typedef struct packed {
    logic [bic_pkg::ACC_WIDTH-1:0]   out_index;
    bic_pkg::coord_arr_t             coord;
    logic                            bad;
  } conv_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [bic_pkg::CFG_IDX_WIDTH-1:0] cfg_idx = '0;
  logic [bic_pkg::COORD_WIDTH-1:0] cfg_wdata = '0;
  logic drv_valid = 1'b0;
  conv_req_t drv_item = '0;
  logic rsp_rdy = 1'b0;
  logic req_taken = 1'b0;

  bic_req_if req();
  bic_rsp_if rsp();

  assign req.valid = drv_valid;
  assign req.cmd = drv_item.cmd;
  assign req.coord_0 = drv_item.coord[0];
  assign req.coord_1 = drv_item.coord[1];
  assign req.coord_2 = drv_item.coord[2];
  assign req.index = drv_item.index;
  assign rsp.ready = rsp_rdy;

  box_index_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Shadow copy of the box registers.
  logic [1:0] box_dims = 2'd1;
  logic [bic_pkg::COORD_WIDTH-1:0] box_lo [bic_pkg::MAX_DIMS] = '{default: '0};
  logic [bic_pkg::COORD_WIDTH-1:0] box_hi [bic_pkg::MAX_DIMS] = '{default: '0};

  conv_req_t pending_q[$];
  conv_rsp_t expect_q[$];
  int unsigned cycle_cnt = 0;
  int unsigned quiet_cnt = 0;
  int unsigned hold_left = 0;
  bit hold_start = 1'b0;
  bit hold_done = 1'b0;
  bit send_hold = 1'b0;
  int errors = 0;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic logic [63:0] sx(logic [bic_pkg::COORD_WIDTH-1:0] v);
    return {{(64-bic_pkg::COORD_WIDTH){v[bic_pkg::COORD_WIDTH-1]}}, v};
  endfunction

  function automatic int dims_used();
    return (box_dims == 2'd0) ? 1 : int'(box_dims);
  endfunction

  function automatic logic [63:0] extent(int d);
    return sx(box_hi[d]) - sx(box_lo[d]) + 64'd1;
  endfunction

  function automatic conv_rsp_t convert(conv_req_t r);
    int n;
    logic [63:0] ext [bic_pkg::MAX_DIMS];
    logic [63:0] acc;
    logic [63:0] rem;
    bit bad;
    conv_rsp_t o;
    o = '0;
    bad = 1'b0;
    n = dims_used();
    for (int d = 0; d < n; d++) begin
      ext[d] = extent(d);
      if (ext[d] == 64'd0 || ext[d][63]) bad = 1'b1;
    end
    if (bad) begin
      o.bad = 1'b1;
      return o;
    end
    if (r.cmd == bic_pkg::CMD_LIN) begin
      acc = '0;
      for (int d = 0; d < n; d++) acc = acc * ext[d] + (sx(r.coord[d]) - sx(box_lo[d]));
      o.out_index = acc;
    end else begin
      rem = {1'b0, r.index};
      for (int d = n - 1; d >= 0; d--) begin
        acc = rem % ext[d] + sx(box_lo[d]);
        o.coord[d] = acc[bic_pkg::COORD_WIDTH-1:0];
        rem = rem / ext[d];
      end
    end
    return o;
  endfunction

  function automatic bit idle_roll();
    if (cycle_cnt >= 1500 && cycle_cnt < 3500) return 1'b0;
    return $urandom_range(0, 99) < 32;
  endfunction

  always @(negedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!drv_valid || req_taken) begin
      if (pending_q.size() > 0 && !send_hold && !idle_roll()) begin
        drv_valid <= 1'b1;
        drv_item <= pending_q[0];
      end else begin
        drv_valid <= 1'b0;
      end
    end
    req_taken <= 1'b0;
  end

  // Receiver; one long hold-off is started on request to back up the chain.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_rdy <= 1'b0;
    end else if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      rsp_rdy <= 1'b0;
    end else begin
      rsp_rdy <= !idle_roll();
    end
  end

  always @(posedge clk_i) begin
    conv_rsp_t want;
    conv_rsp_t got;
    if (rst_ni) begin
      if (req.valid && req.ready) begin
        expect_q.push_back(convert(pending_q[0]));
        void'(pending_q.pop_front());
        req_taken <= 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        got.out_index = rsp.out_index;
        got.coord[0] = rsp.out_coord_0;
        got.coord[1] = rsp.out_coord_1;
        got.coord[2] = rsp.out_coord_2;
        got.bad = rsp.bad_box;
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", got);
        end else begin
          want = expect_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: index exp %h got %h", want.out_index, got.out_index);
              $display("  coords exp %h %h %h got %h %h %h", want.coord[0], want.coord[1],
                       want.coord[2], got.coord[0], got.coord[1], got.coord[2]);
              $display("  bad_box exp %b got %b", want.bad, got.bad);
            end
          end
        end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (pending_q.size() == 0 && expect_q.size() == 0)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  task automatic write_reg(logic [bic_pkg::CFG_IDX_WIDTH-1:0] idx,
                           logic [bic_pkg::COORD_WIDTH-1:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == bic_pkg::REG_DIMS) begin
      box_dims = data[1:0];
    end else if (idx >= bic_pkg::REG_LO0 && idx < bic_pkg::REG_LO0 + bic_pkg::MAX_DIMS) begin
      box_lo[idx - bic_pkg::REG_LO0] = data;
    end else if (idx >= bic_pkg::REG_HI0 && idx < bic_pkg::REG_HI0 + bic_pkg::MAX_DIMS) begin
      box_hi[idx - bic_pkg::REG_HI0] = data;
    end
  endtask

  task automatic set_box(logic [bic_pkg::COORD_WIDTH-1:0] dims,
                         logic [bic_pkg::COORD_WIDTH-1:0] lo0,
                         logic [bic_pkg::COORD_WIDTH-1:0] lo1,
                         logic [bic_pkg::COORD_WIDTH-1:0] lo2,
                         logic [bic_pkg::COORD_WIDTH-1:0] hi0,
                         logic [bic_pkg::COORD_WIDTH-1:0] hi1,
                         logic [bic_pkg::COORD_WIDTH-1:0] hi2);
    write_reg(bic_pkg::REG_DIMS, dims);
    write_reg(bic_pkg::REG_LO0, lo0);
    write_reg(bic_pkg::REG_LO0 + 3'd1, lo1);
    write_reg(bic_pkg::REG_LO0 + 3'd2, lo2);
    write_reg(bic_pkg::REG_HI0, hi0);
    write_reg(bic_pkg::REG_HI0 + 3'd1, hi1);
    write_reg(bic_pkg::REG_HI0 + 3'd2, hi2);
  endtask

  // Returns once all requests are taken and all results have come back.
  task automatic drain();
    while (pending_q.size() != 0 || expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_req(logic cmd, logic [bic_pkg::COORD_WIDTH-1:0] c0,
                          logic [bic_pkg::COORD_WIDTH-1:0] c1,
                          logic [bic_pkg::COORD_WIDTH-1:0] c2,
                          logic [bic_pkg::IDX_WIDTH-1:0] idx);
    conv_req_t r;
    r.cmd = cmd;
    r.coord[0] = c0;
    r.coord[1] = c1;
    r.coord[2] = c2;
    r.index = idx;
    pending_q.push_back(r);
  endtask

  // Mostly points inside the box and indexes of every magnitude, some raw noise.
  task automatic push_random(int count);
    conv_req_t r;
    logic [63:0] ext;
    logic [63:0] pick;
    for (int k = 0; k < count; k++) begin
      r.cmd = $urandom_range(0, 1) ? bic_pkg::CMD_DELIN : bic_pkg::CMD_LIN;
      for (int d = 0; d < bic_pkg::MAX_DIMS; d++) begin
        ext = extent(d);
        if ($urandom_range(0, 9) < 7 && ext != 0 && !ext[63]) begin
          pick = {$urandom, $urandom} % ext;
          r.coord[d] = box_lo[d] + pick[bic_pkg::COORD_WIDTH-1:0];
        end else begin
          r.coord[d] = $urandom;
        end
      end
      pick = {$urandom, $urandom} >> $urandom_range(0, 62);
      r.index = pick[bic_pkg::IDX_WIDTH-1:0];
      pending_q.push_back(r);
    end
  endtask

  initial begin
    logic [bic_pkg::COORD_WIDTH-1:0] lo_r [bic_pkg::MAX_DIMS];
    logic [bic_pkg::COORD_WIDTH-1:0] span;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    push_random(10);
    drain();

    // A write to the spare index must change nothing; dims of zero acts as one.
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    write_reg(bic_pkg::REG_DIMS, 32'd0);
    write_reg(bic_pkg::REG_HI0, 32'd9);
    push_random(10);
    drain();

    set_box(32'd3, -32'sd5, 32'd10, 32'h8000_0000, 32'd4, 32'd13, 32'h8000_0006);
    push_req(bic_pkg::CMD_LIN, -32'sd5, 32'd10, 32'h8000_0000, '0);
    push_req(bic_pkg::CMD_LIN, 32'd4, 32'd13, 32'h8000_0006, '0);
    push_req(bic_pkg::CMD_LIN, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
    push_req(bic_pkg::CMD_LIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1);
    push_req(bic_pkg::CMD_LIN, 32'd0, 32'hFFFF_FFFF, 32'd0, '0);
    push_req(bic_pkg::CMD_LIN, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, '0);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, '0);
    push_req(bic_pkg::CMD_DELIN, '1, '1, '1, '1);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, 63'd1);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, 63'd279);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, 63'd280);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, {1'b1, 62'd0});
    push_random(84);
    drain();

    // Full 32-bit range in every dimension: linearizing wraps past 2^64.
    set_box(32'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(bic_pkg::CMD_LIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0);
    push_req(bic_pkg::CMD_DELIN, '0, '0, '0, '1);
    push_random(78);
    drain();

    // Long stretch with the receiver held off while the sender keeps going.
    set_box(32'd2, -32'sd100, 32'd0, 32'd0, 32'd100, 32'd999, 32'd0);
    push_random(250);
    hold_start = 1'b1;
    drain();

    // Inverted box in a middle dimension.
    set_box(32'd3, 32'd0, 32'd50, 32'd0, 32'd7, 32'd49, 32'd3);
    push_random(30);
    drain();

    // Empty first dimension; the other dimensions are not in use.
    set_box(32'd4, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd5);
    push_random(10);
    drain();
    set_box(32'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'h8000_0000, 32'd5, 32'd5);
    push_random(10);
    drain();

    for (int p = 0; p < 4; p++) begin
      for (int d = 0; d < bic_pkg::MAX_DIMS; d++) lo_r[d] = $urandom;
      span = (p == 3) ? $urandom : $urandom_range(0, 300);
      set_box($urandom, lo_r[0], lo_r[1], lo_r[2], lo_r[0] + span,
              lo_r[1] + $urandom_range(0, 40), lo_r[2] + $urandom_range(0, 40));
      push_random(40);
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/bic_pkg.sv
rtl/bic_req_if.sv
rtl/bic_rsp_if.sv
rtl/bic_cell.sv
rtl/bic_pass_end.sv
rtl/box_index_converter.sv
verif/tb_box_index_converter.sv
